>>> hw/rtl/lmb_pkg.sv
`default_nettype none
package lmb_pkg;

  localparam int PANEL_WIDTH = 64;
  localparam int SCAN_ROWS   = 16;
  localparam int COLOUR_BITS = 4;

  localparam int COL_W   = $clog2(PANEL_WIDTH);
  localparam int ROW_W   = $clog2(SCAN_ROWS);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int LANE_W  = 12;
  localparam int LANES   = 4;
  localparam int LANE_IW = $clog2(LANES);
  localparam int PLANE_W = 2;
  localparam int ON_W    = 15;
  localparam int CFG_W   = 8;
  localparam int CFG_IW  = 2;
  localparam int RSEL_W  = 4;

  // lane layout of a store word: {b lower, b upper, a lower, a upper}
  localparam int LANE_A_UPPER = 0;
  localparam int LANE_A_LOWER = 1;
  localparam int LANE_B_UPPER = 2;
  localparam int LANE_B_LOWER = 3;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_PRESENT = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_BRIGHTNESS     = 2'd0,
    REG_TICKS_PER_UNIT = 2'd1,
    REG_REFRESH_ENABLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  pixel_x;
    logic [4:0]  pixel_y;
    logic [11:0] pixel_colour;
  } cmd_t;

  typedef struct packed {
    logic              upper_red;
    logic              upper_green;
    logic              upper_blue;
    logic              lower_red;
    logic              lower_green;
    logic              lower_blue;
    logic              shift_clock;
    logic              latch;
    logic              blank;
    logic [RSEL_W-1:0] row_select;
    logic              status;
    logic              frame_start;
  } pins_t;

  // item handed from the sequencer to the pin stage, registered together with its ram read data
  typedef struct packed {
    logic               valid;
    logic               load;
    logic               clear;
    logic               front;
    logic [PLANE_W-1:0] plane;
    logic               shift_clock;
    logic               latch;
    logic               blank;
    logic [RSEL_W-1:0]  row_select;
    logic               status;
    logic               frame_start;
  } stage_t;

  // data bits in pin order: upper r g b, lower r g b
  function automatic logic [5:0] plane_bits(input logic [LANE_W-1:0] upper,
                                            input logic [LANE_W-1:0] lower,
                                            input logic [PLANE_W-1:0] plane);
    logic [5:0] d;
    d[0] = upper[8 + 32'(plane)];
    d[1] = upper[4 + 32'(plane)];
    d[2] = upper[32'(plane)];
    d[3] = lower[8 + 32'(plane)];
    d[4] = lower[4 + 32'(plane)];
    d[5] = lower[32'(plane)];
    return d;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lmb_if.sv
`default_nettype none
interface lmb_cmd_if import lmb_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lmb_pins_if import lmb_pkg::*; ();
  logic  valid;
  logic  ready;
  pins_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/led_matrix_bcm_refresh.sv
`default_nettype none
// Refresh controller for a two-half scanned RGB LED panel with binary code
// modulation. Each accepted item (pixel write, present, or refresh tick) gives
// one pin-state item. One item is accepted per clock cycle unless the pin
// output stalls; it is registered in the stage beside the read of the frame
// memory, which holds both frame stores side by side in one word per scan
// row and column, and then in the pin register. A clearing pass after reset
// zeroes all 1024 words, and no item is accepted until it finishes;
// configuration writes are taken at any time and apply from the next item.
module led_matrix_bcm_refresh import lmb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  lmb_cmd_if.sink                cmd,
  lmb_pins_if.source             pins,
  input  wire logic              cfg_write,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  stage_t                  stage;
  logic                    take;
  logic [LANES-1:0]        ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [LANES*LANE_W-1:0] ram_wdata;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [LANES*LANE_W-1:0] ram_rdata;

  lmb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .stage     (stage),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  lmb_ram #(
    .ADDR_W (ADDR_W),
    .LANE_W (LANE_W),
    .LANES  (LANES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lmb_out u_out (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .rdata (ram_rdata),
    .take  (take),
    .pins  (pins)
  );

  // a stalled item must keep its slot until the pin stage takes it
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && !take) |=> (stage.valid && $stable(stage)))
    else $error("pending item lost or changed while stalled");

  // a read is only issued by a tick, never together with a write
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (ram_we == '0))
    else $error("frame memory read and write in the same cycle");

  // latch only strobes while the panel is dark
  a_latch_blank: assert property (@(posedge clk) disable iff (rst)
    pins.valid |-> (!pins.data.latch || pins.data.blank))
    else $error("latch high with output enabled");

endmodule
`default_nettype wire

>>> hw/rtl/lmb_ram.sv
`default_nettype none
module lmb_ram #(
  parameter int ADDR_W = 10,
  parameter int LANE_W = 12,
  parameter int LANES  = 4
) (
  input  wire logic                      clk,
  input  wire logic [LANES-1:0]          we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [LANES*LANE_W-1:0]   wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [LANES*LANE_W-1:0]   rdata
);

  logic [LANES*LANE_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (we[l]) begin
        mem[waddr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
      end
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lmb_seq.sv
`default_nettype none
module lmb_seq import lmb_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  lmb_cmd_if.sink                      cmd,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IW-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic                    take,
  output stage_t                       stage,
  output logic      [LANES-1:0]        ram_we,
  output logic      [ADDR_W-1:0]       ram_waddr,
  output logic      [LANES*LANE_W-1:0] ram_wdata,
  output logic                         ram_re,
  output logic      [ADDR_W-1:0]       ram_raddr
);

  typedef enum logic [4:0] {
    PH_SHIFT = 5'b00001,
    PH_CLOCK = 5'b00010,
    PH_BLANK = 5'b00100,
    PH_LATCH = 5'b01000,
    PH_ON    = 5'b10000
  } phase_e;

  logic [ADDR_W:0]    clr_cnt;
  logic               clear_done;
  logic               accept;

  logic [4:0]         brightness;
  logic [7:0]         ticks_per_unit;
  logic               refresh_enable;

  logic               front_is_b, front_is_b_next;
  logic               swap_waiting, swap_waiting_next;
  logic [PLANE_W-1:0] plane, plane_next;
  logic [ROW_W-1:0]   scan_row, scan_row_next;
  logic [COL_W-1:0]   column, column_next;
  phase_e             phase, phase_next;
  logic [ON_W-1:0]    on_left, on_left_next;
  logic               pin_clk, pin_clk_next;
  logic               pin_lat, pin_lat_next;
  logic               pin_blank, pin_blank_next;
  logic [RSEL_W-1:0]  pin_row, pin_row_next;

  stage_t             stage_new;
  logic [4:0]         br_eff;
  logic [7:0]         tp_eff;
  logic [12:0]        on_prod;
  logic [15:0]        on_shift;
  logic               wr_half;
  logic [ROW_W-1:0]   wr_row;
  logic [LANE_IW-1:0] wr_lane;
  logic               wr_in_panel;

  assign clear_done = clr_cnt[ADDR_W];
  assign cmd.ready  = clear_done && (!stage.valid || take);
  assign accept     = cmd.valid && cmd.ready;

  // on-time weight, loaded in the latch phase
  assign br_eff   = (brightness == 5'd0) ? 5'd8 : brightness;
  assign tp_eff   = (ticks_per_unit == 8'd0) ? 8'd1 : ticks_per_unit;
  assign on_prod  = 13'(br_eff) * 13'(tp_eff);
  assign on_shift = 16'(on_prod) << plane;

  assign wr_in_panel = (32'(cmd.data.pixel_x) < PANEL_WIDTH)
                    && (32'(cmd.data.pixel_y) < 2 * SCAN_ROWS);
  assign wr_half = 32'(cmd.data.pixel_y) >= SCAN_ROWS;
  assign wr_row  = wr_half ? ROW_W'(32'(cmd.data.pixel_y) - SCAN_ROWS)
                           : ROW_W'(cmd.data.pixel_y);
  assign wr_lane = front_is_b ? (wr_half ? LANE_IW'(LANE_A_LOWER) : LANE_IW'(LANE_A_UPPER))
                              : (wr_half ? LANE_IW'(LANE_B_LOWER) : LANE_IW'(LANE_B_UPPER));

  always_comb begin
    front_is_b_next   = front_is_b;
    swap_waiting_next = swap_waiting;
    plane_next        = plane;
    scan_row_next     = scan_row;
    column_next       = column;
    phase_next        = phase;
    on_left_next      = on_left;
    pin_clk_next      = pin_clk;
    pin_lat_next      = pin_lat;
    pin_blank_next    = pin_blank;
    pin_row_next      = pin_row;
    stage_new         = '0;
    ram_we            = '0;
    ram_waddr         = {wr_row, COL_W'(cmd.data.pixel_x)};
    ram_wdata         = {LANES{cmd.data.pixel_colour}};
    ram_re            = 1'b0;
    ram_raddr         = {scan_row, column};

    if (!clear_done) begin
      ram_we    = '1;
      ram_waddr = clr_cnt[ADDR_W-1:0];
      ram_wdata = '0;
    end

    if (accept) begin
      unique case (op_e'(cmd.data.opcode))
        OP_WRITE: begin
          if (swap_waiting) begin
            stage_new.status = 1'b1;
          end else if (wr_in_panel) begin
            ram_we = LANES'(1) << wr_lane;
          end
        end
        OP_PRESENT: begin
          if (swap_waiting) begin
            stage_new.status = 1'b1;
          end else if (refresh_enable) begin
            swap_waiting_next = 1'b1;
          end else begin
            front_is_b_next = !front_is_b;
          end
        end
        OP_TICK: begin
          if (!refresh_enable) begin
            if (swap_waiting) begin
              front_is_b_next   = !front_is_b;
              swap_waiting_next = 1'b0;
            end
            plane_next      = '0;
            scan_row_next   = '0;
            column_next     = '0;
            phase_next      = PH_SHIFT;
            on_left_next    = '0;
            pin_clk_next    = 1'b0;
            pin_lat_next    = 1'b0;
            pin_blank_next  = 1'b1;
            pin_row_next    = '0;
            stage_new.clear = 1'b1;
          end else begin
            unique case (phase)
              PH_SHIFT: begin
                if (plane == '0 && scan_row == '0 && column == '0) begin
                  stage_new.frame_start = 1'b1;
                  if (swap_waiting) begin
                    front_is_b_next   = !front_is_b;
                    swap_waiting_next = 1'b0;
                  end
                end
                pin_clk_next   = 1'b0;
                pin_lat_next   = 1'b0;
                pin_blank_next = 1'b1;
                stage_new.load = 1'b1;
                ram_re         = 1'b1;
                phase_next     = PH_CLOCK;
              end
              PH_CLOCK: begin
                pin_clk_next = 1'b1;
                if (column == COL_W'(PANEL_WIDTH - 1)) begin
                  column_next = '0;
                  phase_next  = PH_BLANK;
                end else begin
                  column_next = column + COL_W'(1);
                  phase_next  = PH_SHIFT;
                end
              end
              PH_BLANK: begin
                pin_clk_next   = 1'b0;
                pin_blank_next = 1'b1;
                phase_next     = PH_LATCH;
              end
              PH_LATCH: begin
                pin_clk_next   = 1'b0;
                pin_lat_next   = 1'b1;
                pin_blank_next = 1'b1;
                pin_row_next   = RSEL_W'(scan_row);
                on_left_next   = on_shift[ON_W-1:0];
                phase_next     = PH_ON;
              end
              PH_ON: begin
                pin_clk_next   = 1'b0;
                pin_lat_next   = 1'b0;
                pin_blank_next = 1'b0;
                if (on_left > ON_W'(1)) begin
                  on_left_next = on_left - ON_W'(1);
                end else begin
                  on_left_next = '0;
                  phase_next   = PH_SHIFT;
                  if (scan_row == ROW_W'(SCAN_ROWS - 1)) begin
                    scan_row_next = '0;
                    plane_next    = (plane == PLANE_W'(COLOUR_BITS - 1))
                                  ? '0 : plane + PLANE_W'(1);
                  end else begin
                    scan_row_next = scan_row + ROW_W'(1);
                  end
                end
              end
              default: begin
                plane_next      = '0;
                scan_row_next   = '0;
                column_next     = '0;
                phase_next      = PH_SHIFT;
                on_left_next    = '0;
                pin_clk_next    = 1'b0;
                pin_lat_next    = 1'b0;
                pin_blank_next  = 1'b1;
                pin_row_next    = '0;
                stage_new.clear = 1'b1;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    stage_new.valid       = 1'b1;
    stage_new.front       = front_is_b_next;
    stage_new.plane       = plane;
    stage_new.shift_clock = pin_clk_next;
    stage_new.latch       = pin_lat_next;
    stage_new.blank       = pin_blank_next;
    stage_new.row_select  = pin_row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clear_done) begin
      clr_cnt <= clr_cnt + (ADDR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness     <= 5'd8;
      ticks_per_unit <= 8'd1;
      refresh_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_BRIGHTNESS:     brightness <= (cfg_data > CFG_W'(16)) ? 5'd16 : cfg_data[4:0];
        REG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data;
        REG_REFRESH_ENABLE: refresh_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_is_b   <= 1'b0;
      swap_waiting <= 1'b0;
      plane        <= '0;
      scan_row     <= '0;
      column       <= '0;
      phase        <= PH_SHIFT;
      on_left      <= '0;
      pin_clk      <= 1'b0;
      pin_lat      <= 1'b0;
      pin_blank    <= 1'b1;
      pin_row      <= '0;
    end else begin
      front_is_b   <= front_is_b_next;
      swap_waiting <= swap_waiting_next;
      plane        <= plane_next;
      scan_row     <= scan_row_next;
      column       <= column_next;
      phase        <= phase_next;
      on_left      <= on_left_next;
      pin_clk      <= pin_clk_next;
      pin_lat      <= pin_lat_next;
      pin_blank    <= pin_blank_next;
      pin_row      <= pin_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage <= stage_new;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lmb_out.sv
`default_nettype none
module lmb_out import lmb_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire stage_t                  stage,
  input  wire logic [LANES*LANE_W-1:0] rdata,
  output logic                         take,
  lmb_pins_if.source                   pins
);

  logic              out_valid;
  pins_t             out_q;
  logic [5:0]        data_q;
  logic [5:0]        data_new;
  logic [LANE_W-1:0] upper;
  logic [LANE_W-1:0] lower;

  assign take = stage.valid && (!out_valid || pins.ready);

  assign upper = stage.front ? rdata[LANE_B_UPPER*LANE_W +: LANE_W]
                             : rdata[LANE_A_UPPER*LANE_W +: LANE_W];
  assign lower = stage.front ? rdata[LANE_B_LOWER*LANE_W +: LANE_W]
                             : rdata[LANE_A_LOWER*LANE_W +: LANE_W];

  // data pins change only on a column load or a forced blank
  always_comb begin
    if (stage.load) begin
      data_new = plane_bits(upper, lower, stage.plane);
    end else if (stage.clear) begin
      data_new = '0;
    end else begin
      data_new = data_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      data_q    <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      data_q    <= data_new;
    end else if (pins.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_q.upper_red   <= data_new[0];
      out_q.upper_green <= data_new[1];
      out_q.upper_blue  <= data_new[2];
      out_q.lower_red   <= data_new[3];
      out_q.lower_green <= data_new[4];
      out_q.lower_blue  <= data_new[5];
      out_q.shift_clock <= stage.shift_clock;
      out_q.latch       <= stage.latch;
      out_q.blank       <= stage.blank;
      out_q.row_select  <= stage.row_select;
      out_q.status      <= stage.status;
      out_q.frame_start <= stage.frame_start;
    end
  end

  assign pins.valid = out_valid;
  assign pins.data  = out_q;

endmodule
`default_nettype wire
